>>> rtl/dmsh_pkg.sv
// shared types, constants and codes of the direct-mapped string hash table
`default_nettype none
package dmsh_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int MAX_KEY_BYTES = 32;
  localparam int KLEN_W        = $clog2(MAX_KEY_BYTES + 1);
  localparam int KIDX_W        = $clog2(MAX_KEY_BYTES);
  localparam int KEY_ROW_W     = MAX_KEY_BYTES * 8;
  localparam int VALUE_BITS    = 32;
  localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);
  localparam int START_W       = 11;
  localparam int HASH_SEED     = 5381;
  localparam logic [SLOT_W-1:0] HASH_INIT = SLOT_W'(HASH_SEED % TABLE_ENTRIES);

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_SCAN   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_OCCUPIED  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_END       = 3'd4;

  typedef struct packed {
    logic [1:0]            kind;
    logic [7:0]            key_byte;
    logic [VALUE_BITS-1:0] value;
    logic [START_W-1:0]    start_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [9:0]            slot_index;
    logic [31:0]           found_value;
    logic [10:0]           entry_count;
    logic [5:0]            found_key_length;
  } out_word_t;

  // per-slot metadata row
  typedef struct packed {
    logic                  valid;
    logic [KLEN_W-1:0]     klen;
    logic [VALUE_BITS-1:0] value;
  } meta_t;

  // pending key status
  typedef struct packed {
    logic [KLEN_W-1:0]     len;
    logic                  ovf;
    logic [SLOT_W-1:0]     hash;
  } pend_t;

endpackage
`default_nettype wire

>>> rtl/dmsh_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module dmsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/dmsh_pend.sv
// pending key buffer with running djb2 hash
`default_nettype none
module dmsh_pend (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          app_en,
  input  wire logic [7:0]                    app_byte,
  input  wire logic                          clr_en,
  output dmsh_pkg::pend_t                    pend,
  output logic [dmsh_pkg::KEY_ROW_W-1:0]     key_row
);
  import dmsh_pkg::*;

  logic [7:0]        key_r [MAX_KEY_BYTES];
  logic [KLEN_W-1:0] len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [SLOT_W-1:0] hash_r, hash_nxt;
  logic              room;

  assign room = (len_r < KLEN_W'(MAX_KEY_BYTES));

  always_comb begin
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    hash_nxt = hash_r;
    if (clr_en) begin
      len_nxt  = '0;
      ovf_nxt  = 1'b0;
      hash_nxt = HASH_INIT;
    end else if (app_en) begin
      if (room) begin
        len_nxt  = len_r + KLEN_W'(1);
        // h*33 + byte kept modulo the table size
        hash_nxt = (hash_r << 5) + hash_r + SLOT_W'(app_byte);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      ovf_r  <= 1'b0;
      hash_r <= HASH_INIT;
    end else begin
      len_r  <= len_nxt;
      ovf_r  <= ovf_nxt;
      hash_r <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (app_en && !clr_en && room) begin
      key_r[len_r[KIDX_W-1:0]] <= app_byte;
    end
  end

  for (genvar i = 0; i < MAX_KEY_BYTES; i++) begin : g_row
    assign key_row[i*8 +: 8] = key_r[i];
  end

  assign pend.len  = len_r;
  assign pend.ovf  = ovf_r;
  assign pend.hash = hash_r;

endmodule
`default_nettype wire

>>> rtl/direct_mapped_string_hash_table_top.sv
// top level of the direct-mapped string hash table
// key byte words can follow back to back while the control is idle
// insert and lookup do one slot read, then compare and write back once the result register is free
// scan reads slot after slot from the start index until a valid slot or the table end is met
// after reset a sweep over all 1024 slots clears the slot valid bits; no word is taken meanwhile
// the result register lets a new word in while a finished result waits
`default_nettype none
module direct_mapped_string_hash_table_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire dmsh_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dmsh_pkg::out_word_t      out_word
);
  import dmsh_pkg::*;

  // one-hot control states
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CMD   = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [SLOT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic               scan_end_r, scan_end_nxt;
  logic [1:0]         cmd_kind_r, cmd_kind_nxt;
  logic [VALUE_BITS-1:0] cmd_value_r, cmd_value_nxt;
  logic [COUNT_W-1:0] occ_r, occ_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_r, out_nxt;

  logic               accept;
  logic               out_free;
  logic               out_ld;
  logic               ins_ok;

  // pending key
  pend_t              pend;
  logic [KEY_ROW_W-1:0] pend_key;
  logic               app_en;
  logic               clr_en;

  // memories
  logic               meta_wr_en, meta_rd_en;
  logic [SLOT_W-1:0]  meta_wr_addr, meta_rd_addr;
  meta_t              meta_wr, meta_rd;
  logic [$bits(meta_t)-1:0] meta_rd_bits;
  logic               key_wr_en, key_rd_en;
  logic [KEY_ROW_W-1:0] key_rd;

  // compare of stored key against pending key
  logic [MAX_KEY_BYTES-1:0] byte_eq;
  logic               hit;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign app_en   = accept && (in_word.kind == KIND_APPEND);
  assign meta_rd  = meta_t'(meta_rd_bits);

  dmsh_pend u_pend (
    .clk      (clk),
    .rst_n    (rst_n),
    .app_en   (app_en),
    .app_byte (in_word.key_byte),
    .clr_en   (clr_en),
    .pend     (pend),
    .key_row  (pend_key)
  );

  // valid bit, key length and value of each slot
  dmsh_ram #(.WIDTH($bits(meta_t)), .DEPTH(TABLE_ENTRIES)) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_wr_en),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wr),
    .rd_en   (meta_rd_en),
    .rd_addr (meta_rd_addr),
    .rd_data (meta_rd_bits)
  );

  // key bytes of each slot, one row per slot
  dmsh_ram #(.WIDTH(KEY_ROW_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_wr_en),
    .wr_addr (pend.hash),
    .wr_data (pend_key),
    .rd_en   (key_rd_en),
    .rd_addr (pend.hash),
    .rd_data (key_rd)
  );

  // bytes past the pending length do not take part
  for (genvar i = 0; i < MAX_KEY_BYTES; i++) begin : g_cmp
    assign byte_eq[i] = (KLEN_W'(i) >= pend.len) ||
                        (key_rd[i*8 +: 8] == pend_key[i*8 +: 8]);
  end

  assign hit = meta_rd.valid && (meta_rd.klen == pend.len) && (&byte_eq);

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    scan_idx_nxt  = scan_idx_r;
    scan_end_nxt  = scan_end_r;
    cmd_kind_nxt  = cmd_kind_r;
    cmd_value_nxt = cmd_value_r;
    occ_nxt       = occ_r;
    out_nxt       = out_r;
    out_ld        = 1'b0;
    ins_ok        = 1'b0;
    clr_en        = 1'b0;
    meta_wr_en    = 1'b0;
    meta_wr_addr  = pend.hash;
    meta_wr       = '0;
    meta_rd_en    = 1'b0;
    meta_rd_addr  = pend.hash;
    key_wr_en     = 1'b0;
    key_rd_en     = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // sweep valid bits to zero
        meta_wr_en   = 1'b1;
        meta_wr_addr = clr_idx_r;
        clr_idx_nxt  = clr_idx_r + SLOT_W'(1);
        if (clr_idx_r == SLOT_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_kind_nxt  = in_word.kind;
          cmd_value_nxt = in_word.value;
          case (in_word.kind)
            KIND_INSERT, KIND_LOOKUP: begin
              meta_rd_en = 1'b1;
              key_rd_en  = 1'b1;
              state_nxt  = S_CMD;
            end
            KIND_SCAN: begin
              state_nxt = S_SCAN;
              if (in_word.start_index >= START_W'(TABLE_ENTRIES)) begin
                scan_end_nxt = 1'b1;
              end else begin
                scan_end_nxt = 1'b0;
                scan_idx_nxt = in_word.start_index[SLOT_W-1:0];
                meta_rd_en   = 1'b1;
                meta_rd_addr = in_word.start_index[SLOT_W-1:0];
              end
            end
            default: begin
              // key byte goes to the pending buffer
            end
          endcase
        end
      end
      S_CMD: begin
        if (out_free) begin
          out_ld                   = 1'b1;
          clr_en                   = 1'b1;
          state_nxt                = S_IDLE;
          out_nxt.slot_index       = 10'(pend.hash);
          out_nxt.found_value      = '0;
          out_nxt.found_key_length = '0;
          out_nxt.entry_count      = 11'(occ_r);
          if (pend.ovf) begin
            out_nxt.status = ST_TOO_LONG;
          end else if (cmd_kind_r == KIND_INSERT) begin
            if (meta_rd.valid) begin
              out_nxt.status = ST_OCCUPIED;
            end else begin
              ins_ok              = 1'b1;
              occ_nxt             = occ_r + COUNT_W'(1);
              out_nxt.status      = ST_OK;
              out_nxt.entry_count = 11'(occ_nxt);
              meta_wr_en          = 1'b1;
              meta_wr.valid       = 1'b1;
              meta_wr.klen        = pend.len;
              meta_wr.value       = cmd_value_r;
              key_wr_en           = 1'b1;
            end
          end else if (hit) begin
            out_nxt.status           = ST_OK;
            out_nxt.found_value      = 32'(meta_rd.value);
            out_nxt.found_key_length = 6'(meta_rd.klen);
          end else begin
            out_nxt.status = ST_NOT_FOUND;
          end
        end
      end
      S_SCAN: begin
        if (scan_end_r) begin
          if (out_free) begin
            out_ld                   = 1'b1;
            state_nxt                = S_IDLE;
            out_nxt.status           = ST_END;
            out_nxt.slot_index       = '0;
            out_nxt.found_value      = '0;
            out_nxt.found_key_length = '0;
            out_nxt.entry_count      = 11'(occ_r);
          end
        end else if (meta_rd.valid) begin
          if (out_free) begin
            out_ld                   = 1'b1;
            state_nxt                = S_IDLE;
            out_nxt.status           = ST_OK;
            out_nxt.slot_index       = 10'(scan_idx_r);
            out_nxt.found_value      = 32'(meta_rd.value);
            out_nxt.found_key_length = 6'(meta_rd.klen);
            out_nxt.entry_count      = 11'(occ_r);
          end
        end else if (scan_idx_r == SLOT_W'(TABLE_ENTRIES - 1)) begin
          scan_end_nxt = 1'b1;
        end else begin
          // read the next slot while this one is judged empty
          scan_idx_nxt = scan_idx_r + SLOT_W'(1);
          meta_rd_en   = 1'b1;
          meta_rd_addr = scan_idx_nxt;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    out_valid_nxt = out_ld ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      scan_end_r  <= 1'b0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      scan_end_r  <= scan_end_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    cmd_kind_r  <= cmd_kind_nxt;
    cmd_value_r <= cmd_value_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // a stored insert bumps the entry count by one
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> (occ_r == $past(occ_r) + COUNT_W'(1)))
    else $error("entry count did not step on insert");

  // the entry count never passes the table size
  a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= COUNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  // an overflowed key always holds the maximum length
  a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
    pend.ovf |-> (pend.len == KLEN_W'(MAX_KEY_BYTES)))
    else $error("key overflow without full pending key");

  // a result loads only while the result register can take it
  a_out_ld: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire

>>> verif/direct_mapped_string_hash_table_top_test.sv
// testbench of the direct-mapped string hash table: directed and random key streams checked against a predictor
`default_nettype none
module direct_mapped_string_hash_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dmsh_pkg::*;

  // table predictor and queue of expected result words
  class hash_table_scoreboard;
    bit                  valid_bits [TABLE_ENTRIES];
    logic [5:0]          stored_len [TABLE_ENTRIES];
    logic [7:0]          stored_key [TABLE_ENTRIES][MAX_KEY_BYTES];
    logic [31:0]         stored_value [TABLE_ENTRIES];
    logic [7:0]          pend_key [MAX_KEY_BYTES];
    int unsigned         pend_len;
    bit                  pend_ovf;
    logic [9:0]          hash;
    logic [10:0]         count;
    out_word_t           expected_words [$];
    int                  errors;

    function void clear_pending();
      pend_len = 0;
      pend_ovf = 0;
      hash = HASH_INIT;
    endfunction

    function void reset_state();
      foreach (valid_bits[i]) valid_bits[i] = 0;
      count = 0;
      errors = 0;
      clear_pending();
    endfunction

    // predict the result (if any) of one accepted word
    function void note_input(in_word_t w);
      out_word_t r;
      bit same;
      r = '0;
      r.slot_index = hash;
      case (w.kind)
        KIND_APPEND: begin
          if (pend_len < MAX_KEY_BYTES) begin
            pend_key[pend_len] = w.key_byte;
            pend_len++;
            hash = 10'((hash * 33 + w.key_byte) % TABLE_ENTRIES);
          end else begin
            pend_ovf = 1;
          end
          return;
        end
        KIND_INSERT: begin
          if (pend_ovf) r.status = ST_TOO_LONG;
          else if (valid_bits[hash]) r.status = ST_OCCUPIED;
          else begin
            valid_bits[hash] = 1;
            stored_len[hash] = 6'(pend_len);
            for (int i = 0; i < pend_len; i++) stored_key[hash][i] = pend_key[i];
            stored_value[hash] = w.value;
            count++;
            r.status = ST_OK;
          end
          clear_pending();
        end
        KIND_LOOKUP: begin
          same = valid_bits[hash] && stored_len[hash] == pend_len;
          if (same)
            for (int i = 0; i < pend_len; i++)
              if (stored_key[hash][i] != pend_key[i]) same = 0;
          if (pend_ovf) r.status = ST_TOO_LONG;
          else if (same) begin
            r.status = ST_OK;
            r.found_value = stored_value[hash];
            r.found_key_length = stored_len[hash];
          end else r.status = ST_NOT_FOUND;
          clear_pending();
        end
        default: begin
          r.status = ST_END;
          r.slot_index = '0;
          for (int i = w.start_index; i < TABLE_ENTRIES; i++)
            if (valid_bits[i]) begin
              r.status = ST_OK;
              r.slot_index = 10'(i);
              r.found_value = stored_value[i];
              r.found_key_length = stored_len[i];
              break;
            end
        end
      endcase
      r.entry_count = count;
      expected_words.push_back(r);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, got);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      if (got.status != e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.slot_index != e.slot_index) begin
        $display("%0t: slot_index expected %0d got %0d", $time, e.slot_index, got.slot_index);
        errors++;
      end
      if (got.found_value != e.found_value) begin
        $display("%0t: found_value expected %h got %h", $time, e.found_value,
                 got.found_value);
        errors++;
      end
      if (got.entry_count != e.entry_count) begin
        $display("%0t: entry_count expected %0d got %0d", $time, e.entry_count,
                 got.entry_count);
        errors++;
      end
      if (got.found_key_length != e.found_key_length) begin
        $display("%0t: found_key_length expected %0d got %0d", $time, e.found_key_length,
                 got.found_key_length);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1;
  out_word_t out_word;

  hash_table_scoreboard board = new();
  int  idle_cycles = 0;
  bit  stim_done = 0;
  // slowest step is a full scan plus the clearing sweep after reset
  localparam int WATCHDOG_LIMIT = 20000;

  // keys reused so inserts and lookups meet the same slots
  logic [7:0] key_pool [8][$];

  direct_mapped_string_hash_table_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // gap length: mostly none or short, sometimes long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // acceptance counts as progress for the watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: check accepted words, stall at random
  int out_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_result(out_word);
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1;
      end else begin
        out_stall <= 0;
        if ($urandom_range(99) < 30) out_gap <= gap_len();
      end
    end
  end

  // present one word and hold it until taken, with an optional gap before;
  // valid stays high after acceptance until the next word or a gap drops it
  task automatic send_word(in_word_t w, bit with_gap = 1);
    int g;
    g = with_gap ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    board.note_input(w);
  endtask

  task automatic send_cmd(logic [1:0] kind, logic [31:0] value = '0,
                          logic [10:0] start = '0);
    in_word_t w;
    w = '0;
    w.kind = kind;
    w.value = value;
    w.start_index = start;
    w.key_byte = 8'($urandom);
    send_word(w);
  endtask

  task automatic send_key(logic [7:0] bytes [$]);
    in_word_t w;
    foreach (bytes[i]) begin
      w.kind = KIND_APPEND;
      w.key_byte = bytes[i];
      w.value = $urandom;
      w.start_index = 11'($urandom);
      send_word(w, $urandom_range(3) == 0);
    end
  endtask

  function automatic void random_key(output logic [7:0] k [$], input int len);
    k = {};
    repeat (len) k.push_back(8'($urandom));
  endfunction

  // draining pause: sender drops valid and waits until no result is outstanding
  task automatic drain();
    in_valid <= 0;
    do @(posedge clk); while (board.expected_words.size() != 0);
  endtask

  initial begin
    logic [7:0] k [$];
    int sel;
    int n;
    board.reset_state();
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed part: empty key, extremes, overflow, scans
    send_cmd(KIND_SCAN, 32'h0, 11'd0);
    send_cmd(KIND_LOOKUP);
    send_cmd(KIND_INSERT, 32'hFFFF_FFFF);
    send_cmd(KIND_INSERT, 32'h1);
    send_cmd(KIND_LOOKUP);
    k = {8'h00, 8'hFF};
    send_key(k);
    send_cmd(KIND_INSERT, 32'h0);
    send_key(k);
    send_cmd(KIND_LOOKUP);
    k = {8'h00, 8'hFE};
    send_key(k);
    send_cmd(KIND_LOOKUP);
    random_key(k, MAX_KEY_BYTES);
    send_key(k);
    send_cmd(KIND_INSERT, 32'hA5A5_5A5A);
    send_key(k);
    send_cmd(KIND_LOOKUP);
    random_key(k, MAX_KEY_BYTES + 1);
    send_key(k);
    send_cmd(KIND_INSERT, 32'h1234_5678);
    send_key(k);
    send_cmd(KIND_LOOKUP);
    send_cmd(KIND_SCAN, 32'h0, 11'd1023);
    send_cmd(KIND_SCAN, 32'h0, 11'd1024);
    send_cmd(KIND_SCAN, 32'h0, 11'd2047);
    drain();

    for (int i = 0; i < 8; i++) begin
      random_key(k, $urandom_range(0, MAX_KEY_BYTES));
      key_pool[i] = k;
    end

    // random part: mostly well-formed key streams and commands
    n = 0;
    while (n < 600) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        k = key_pool[$urandom_range(7)];
      end else if (sel < 45) begin
        random_key(k, $urandom_range(MAX_KEY_BYTES, MAX_KEY_BYTES + 3));
      end else begin
        random_key(k, $urandom_range(0, 6));
      end
      send_key(k);
      n += k.size();
      sel = $urandom_range(99);
      if (sel < 45) send_cmd(KIND_INSERT, $urandom);
      else if (sel < 85) send_cmd(KIND_LOOKUP);
      else if (sel < 93) send_cmd(KIND_SCAN, '0, 11'($urandom_range(0, 1023)));
      else send_cmd(KIND_SCAN, '0, 11'($urandom_range(0, 2047)));
      n++;
      if (n > 300 && n < 340) drain();
    end

    drain();
    stim_done = 1;
    repeat (TABLE_ENTRIES + 50) @(posedge clk);
    if (board.errors == 0 && board.expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
